// ===== rtl/udmn_pkg.sv =====
// shared constants and types for the unsigned division magic number core
// no dependencies

package udmn_pkg;

    localparam int unsigned WORD_BITS = 64;
    localparam int unsigned IO_W      = 64;
    localparam int unsigned SHIFT_W   = 7;
    localparam int unsigned CNT_W     = $clog2(WORD_BITS + 1);
    localparam int unsigned P_W       = $clog2(2 * WORD_BITS + 1);

    localparam logic [WORD_BITS-1:0] WMASK = {WORD_BITS{1'b1}};
    localparam logic [WORD_BITS-1:0] WTOP  = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam logic [P_W-1:0]       P_START = P_W'(WORD_BITS - 1);
    localparam logic [P_W-1:0]       P_LIMIT = P_W'(2 * WORD_BITS);
    localparam logic [P_W-1:0]       P_WORD  = P_W'(WORD_BITS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NC,
        ST_Q1,
        ST_Q2,
        ST_STEP,
        ST_CHECK,
        ST_DONE
    } udmn_state_t;

endpackage

// ===== rtl/udmn_div.sv =====
// restoring divider, one quotient bit per cycle, shared by the core sequencer
// depends on udmn_pkg

module udmn_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [udmn_pkg::WORD_BITS-1:0] dividend,
    input  logic [udmn_pkg::WORD_BITS-1:0] divisor,
    output logic                          done,
    output logic [udmn_pkg::WORD_BITS-1:0] quotient,
    output logic [udmn_pkg::WORD_BITS-1:0] remainder
);
    import udmn_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [WORD_BITS-1:0] quo_reg, quo_next;
    logic [WORD_BITS-1:0] rem_reg, rem_next;
    logic [WORD_BITS-1:0] den_reg, den_next;

    logic [WORD_BITS:0]   rem_sh;
    logic [WORD_BITS:0]   rem_sub;
    logic                 ge;

    always_comb begin
        rem_sh  = {rem_reg, quo_reg[WORD_BITS-1]};
        rem_sub = rem_sh - {1'b0, den_reg};
        ge      = (rem_sh >= {1'b0, den_reg});

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;

        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(WORD_BITS);
            quo_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
        end else if (busy_reg) begin
            rem_next = ge ? rem_sub[WORD_BITS-1:0] : rem_sh[WORD_BITS-1:0];
            quo_next = {quo_reg[WORD_BITS-2:0], ge};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ===== rtl/unsigned_div_magic_number_core.sv =====
// top level: sequencer and doubling loop for unsigned division magic numbers
// depends on udmn_pkg and udmn_div
//
// usage:
//   s_valid/s_ready/s_divisor take one divisor d per transfer. s_ready is high
//   only while the sequencer is idle; one divisor is worked on at a time.
//   m_valid/m_ready/m_magic_mult/m_shift_amount/m_add_flag give one result per
//   divisor. the result sits in an output register, so a new divisor can be
//   taken while the previous result still waits for m_ready.
//   sequence: three passes of the bit-serial divider (2^64 mod d,
//   2^63/nc, (2^63-1)/d), each with a handoff, then a doubling step (update,
//   stop test) repeated 1 to 65 times, then the load of the output register.
//   a zero divisor skips the divider and gives all-zero fields.
//   a stalled receiver holds the finished result in the sequencer until the
//   output register frees up.
//   reset: synchronous, active low; clears the sequencer and valid flags.

module unsigned_div_magic_number_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [udmn_pkg::IO_W-1:0]     s_divisor,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [udmn_pkg::IO_W-1:0]     m_magic_mult,
    output logic [udmn_pkg::SHIFT_W-1:0]  m_shift_amount,
    output logic                          m_add_flag
);
    import udmn_pkg::*;

    udmn_state_t state_reg, state_next;

    logic [WORD_BITS-1:0] d_reg, d_next;
    logic [WORD_BITS-1:0] nc_reg, nc_next;
    logic [WORD_BITS-1:0] q1_reg, q1_next;
    logic [WORD_BITS-1:0] r1_reg, r1_next;
    logic [WORD_BITS-1:0] q2_reg, q2_next;
    logic [WORD_BITS-1:0] r2_reg, r2_next;
    logic [P_W-1:0]       p_reg, p_next;
    logic                 add_reg, add_next;
    logic                 zero_reg, zero_next;

    logic                 m_valid_reg, m_valid_next;
    logic [IO_W-1:0]      m_magic_reg, m_magic_next;
    logic [SHIFT_W-1:0]   m_shift_reg, m_shift_next;
    logic                 m_add_reg, m_add_next;

    logic                 div_start;
    logic [WORD_BITS-1:0] div_dividend;
    logic [WORD_BITS-1:0] div_divisor;
    logic                 div_done;
    logic [WORD_BITS-1:0] div_quo;
    logic [WORD_BITS-1:0] div_rem;

    logic [WORD_BITS-1:0] din;
    logic                 din_zero;
    logic                 accept;
    logic                 out_free;
    logic                 keep_going;
    logic                 cond1, cond2;
    logic [WORD_BITS-1:0] delta;

    assign din      = s_divisor[WORD_BITS-1:0];
    assign din_zero = (din == '0);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    udmn_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // stop test operands
    always_comb begin
        delta      = d_reg - WORD_BITS'(1) - r2_reg;
        keep_going = (p_reg < P_LIMIT) &&
                     ((q1_reg < delta) || ((q1_reg == delta) && (r1_reg == '0)));
        cond1      = (r1_reg >= (nc_reg - r1_reg));
        cond2      = ((r2_reg + WORD_BITS'(1)) >= (d_reg - r2_reg));
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = din_zero ? ST_DONE : ST_NC;
                end
            end
            ST_NC: begin
                if (div_done) begin
                    state_next = ST_Q1;
                end
            end
            ST_Q1: begin
                if (div_done) begin
                    state_next = ST_Q2;
                end
            end
            ST_Q2: begin
                if (div_done) begin
                    state_next = ST_STEP;
                end
            end
            ST_STEP: begin
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                state_next = keep_going ? ST_STEP : ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // divider control
    always_comb begin
        div_start    = 1'b0;
        div_dividend = '0 - din;
        div_divisor  = din;
        case (state_reg)
            ST_IDLE: begin
                div_start    = accept && !din_zero;
                div_dividend = '0 - din;
                div_divisor  = din;
            end
            ST_NC: begin
                div_start    = div_done;
                div_dividend = WTOP;
                div_divisor  = WMASK - div_rem;
            end
            ST_Q1: begin
                div_start    = div_done;
                div_dividend = WTOP - WORD_BITS'(1);
                div_divisor  = d_reg;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    // datapath
    always_comb begin
        d_next       = d_reg;
        nc_next      = nc_reg;
        q1_next      = q1_reg;
        r1_next      = r1_reg;
        q2_next      = q2_reg;
        r2_next      = r2_reg;
        p_next       = p_reg;
        add_next     = add_reg;
        zero_next    = zero_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_magic_next = m_magic_reg;
        m_shift_next = m_shift_reg;
        m_add_next   = m_add_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    d_next    = din;
                    zero_next = din_zero;
                end
            end
            ST_NC: begin
                if (div_done) begin
                    nc_next = WMASK - div_rem;
                end
            end
            ST_Q1: begin
                if (div_done) begin
                    q1_next = div_quo;
                    r1_next = div_rem;
                end
            end
            ST_Q2: begin
                if (div_done) begin
                    q2_next  = div_quo;
                    r2_next  = div_rem;
                    p_next   = P_START;
                    add_next = 1'b0;
                end
            end
            ST_STEP: begin
                p_next = p_reg + P_W'(1);
                if (cond1) begin
                    q1_next = {q1_reg[WORD_BITS-2:0], 1'b1};
                    r1_next = {r1_reg[WORD_BITS-2:0], 1'b0} - nc_reg;
                end else begin
                    q1_next = {q1_reg[WORD_BITS-2:0], 1'b0};
                    r1_next = {r1_reg[WORD_BITS-2:0], 1'b0};
                end
                if (cond2) begin
                    if (q2_reg >= (WTOP - WORD_BITS'(1))) begin
                        add_next = 1'b1;
                    end
                    q2_next = {q2_reg[WORD_BITS-2:0], 1'b1};
                    r2_next = {r2_reg[WORD_BITS-2:0], 1'b1} - d_reg;
                end else begin
                    if (q2_reg >= WTOP) begin
                        add_next = 1'b1;
                    end
                    q2_next = {q2_reg[WORD_BITS-2:0], 1'b0};
                    r2_next = {r2_reg[WORD_BITS-2:0], 1'b1};
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (zero_reg) begin
                        m_magic_next = '0;
                        m_shift_next = '0;
                        m_add_next   = 1'b0;
                    end else begin
                        m_magic_next = IO_W'(q2_reg + WORD_BITS'(1));
                        m_shift_next = SHIFT_W'(p_reg - P_WORD);
                        m_add_next   = add_reg;
                    end
                end
            end
            default: begin
                p_next = p_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        d_reg       <= d_next;
        nc_reg      <= nc_next;
        q1_reg      <= q1_next;
        r1_reg      <= r1_next;
        q2_reg      <= q2_next;
        r2_reg      <= r2_next;
        p_reg       <= p_next;
        add_reg     <= add_next;
        zero_reg    <= zero_next;
        m_magic_reg <= m_magic_next;
        m_shift_reg <= m_shift_next;
        m_add_reg   <= m_add_next;
    end

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_magic_mult   = m_magic_reg;
    assign m_shift_amount = m_shift_reg;
    assign m_add_flag     = m_add_reg;

endmodule

// ===== tb/udmn_result_check.sv =====
`timescale 1ns / 100ps
// result checker for the unsigned division magic number core: watches both channels,
// predicts multiplier, shift and add flag for each divisor and compares in order
// depends on udmn_pkg

module udmn_result_check (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic [udmn_pkg::IO_W-1:0]     s_divisor,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [udmn_pkg::IO_W-1:0]     m_magic_mult,
    input  logic [udmn_pkg::SHIFT_W-1:0]  m_shift_amount,
    input  logic                          m_add_flag,
    output int unsigned                   mismatch_count,
    output int unsigned                   results_pending
);

    typedef struct packed {
        logic [udmn_pkg::IO_W-1:0]    mult;
        logic [udmn_pkg::SHIFT_W-1:0] shift;
        logic                         add;
    } magic_t;

    localparam logic [63:0] TOP_BIT = 64'h8000_0000_0000_0000;
    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    magic_t      magic_q[$];
    int unsigned errors  = 0;
    int unsigned waiting = 0;

    assign mismatch_count  = errors;
    assign results_pending = waiting;

    function automatic magic_t compute_magic(input logic [63:0] d);
        logic [63:0] nc;
        logic [63:0] q1;
        logic [63:0] r1;
        logic [63:0] q2;
        logic [63:0] r2;
        logic [63:0] delta;
        int unsigned p;
        logic        add;
        magic_t      res;
        res = '0;
        if (d == 64'd0) begin
            return res;
        end
        nc = ALL_ONES - ((~d + 64'd1) % d);
        q1 = TOP_BIT / nc;
        r1 = TOP_BIT - q1 * nc;
        q2 = (TOP_BIT - 64'd1) / d;
        r2 = (TOP_BIT - 64'd1) - q2 * d;
        p = 63;
        add = 1'b0;
        do begin
            p = p + 1;
            if (r1 >= nc - r1) begin
                q1 = {q1[62:0], 1'b1};
                r1 = {r1[62:0], 1'b0} - nc;
            end else begin
                q1 = {q1[62:0], 1'b0};
                r1 = {r1[62:0], 1'b0};
            end
            if (r2 + 64'd1 >= d - r2) begin
                if (q2 >= TOP_BIT - 64'd1) begin
                    add = 1'b1;
                end
                q2 = {q2[62:0], 1'b1};
                r2 = {r2[62:0], 1'b1} - d;
            end else begin
                if (q2 >= TOP_BIT) begin
                    add = 1'b1;
                end
                q2 = {q2[62:0], 1'b0};
                r2 = {r2[62:0], 1'b1};
            end
            delta = d - 64'd1 - r2;
        end while (p < 128 && (q1 < delta || (q1 == delta && r1 == 64'd0)));
        res.mult  = q2 + 64'd1;
        res.shift = 7'(p - 64);
        res.add   = add;
        return res;
    endfunction

    always @(posedge aclk) begin : watch
        magic_t      want;
        int unsigned bad;
        bad = 0;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (magic_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got mult %h shift %0d add %0b",
                             $time, m_magic_mult, m_shift_amount, m_add_flag);
                    bad = 1;
                end else begin
                    want = magic_q.pop_front();
                    if (m_magic_mult !== want.mult) begin
                        $display("%0t: magic_mult expected %h got %h",
                                 $time, want.mult, m_magic_mult);
                        bad = bad + 1;
                    end
                    if (m_shift_amount !== want.shift) begin
                        $display("%0t: shift_amount expected %0d got %0d",
                                 $time, want.shift, m_shift_amount);
                        bad = bad + 1;
                    end
                    if (m_add_flag !== want.add) begin
                        $display("%0t: add_flag expected %0b got %0b",
                                 $time, want.add, m_add_flag);
                        bad = bad + 1;
                    end
                end
            end
            if (s_valid && s_ready) begin
                magic_q.push_back(compute_magic(s_divisor));
            end
        end
        errors  <= errors + bad;
        waiting <= magic_q.size();
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// top of the testbench for unsigned_div_magic_number_core: clock, reset, divisor
// stimulus under several idle patterns, and the final verdict
// depends on udmn_pkg, unsigned_div_magic_number_core and udmn_result_check

module tb_top;

    localparam int unsigned STALL_LIMIT  = 20000;
    localparam int unsigned DRAIN_CYCLES = 400;
    localparam int unsigned PHASE_ITEMS  = 388;

    logic                          aclk;
    logic                          aresetn;
    logic                          s_valid;
    logic                          s_ready;
    logic [udmn_pkg::IO_W-1:0]     s_divisor;
    logic                          m_valid;
    logic                          m_ready;
    logic [udmn_pkg::IO_W-1:0]     m_magic_mult;
    logic [udmn_pkg::SHIFT_W-1:0]  m_shift_amount;
    logic                          m_add_flag;
    int unsigned                   mismatch_count;
    int unsigned                   results_pending;

    int unsigned src_idle_pct   = 0;
    int unsigned sink_stall_pct = 0;
    int unsigned quiet_cycles;

    unsigned_div_magic_number_core u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_divisor      (s_divisor),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_magic_mult   (m_magic_mult),
        .m_shift_amount (m_shift_amount),
        .m_add_flag     (m_add_flag)
    );

    udmn_result_check u_result_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_divisor       (s_divisor),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_magic_mult    (m_magic_mult),
        .m_shift_amount  (m_shift_amount),
        .m_add_flag      (m_add_flag),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            m_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles = quiet_cycles + 1;
            end
        end
        $display("tb_top NOT OK");
        $finish;
    end

    task automatic send_divisor(input logic [63:0] d);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_divisor <= d;
        do @(posedge aclk); while (!s_ready);
    endtask

    initial begin
        logic [63:0] directed [21];
        logic [63:0] d;
        int unsigned w;
        int unsigned k;
        int unsigned phase;
        directed = '{64'd0, 64'd1, 64'd2, 64'd3, 64'd5, 64'd6, 64'd7, 64'd10, 64'd641,
                     64'h0000_0000_FFFF_FFFF, 64'h0000_0001_0000_0000,
                     64'h0000_0001_0000_0001, 64'h7FFF_FFFF_FFFF_FFFF,
                     64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001,
                     64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE,
                     64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
                     64'h0000_0100_0000_0000, 64'h7000_0000_0000_0000};
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_divisor <= '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i]) begin
            send_divisor(directed[i]);
        end

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
                1: begin
                    src_idle_pct   = 80;
                    sink_stall_pct = 0;
                end
                2: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 80;
                end
                default: begin
                    src_idle_pct   = 7;
                    sink_stall_pct = 7;
                end
            endcase
            repeat (PHASE_ITEMS) begin
                case ($urandom_range(9))
                    0: d = 64'($urandom_range(1000, 1));
                    1: begin
                        k = $urandom_range(63);
                        d = (64'd1 << k) + 64'($urandom_range(2)) - 64'd1;
                    end
                    2, 3: begin
                        w = $urandom_range(64, 1);
                        d = {$urandom, $urandom} & ({64{1'b1}} >> (64 - w));
                        d[w-1] = 1'b1;
                    end
                    default: d = {$urandom, $urandom};
                endcase
                if ($urandom_range(199) == 0) begin
                    d = '0;
                end
                send_divisor(d);
            end
        end
        s_valid <= 1'b0;
        @(posedge aclk);

        while (results_pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && results_pending == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/udmn_pkg.sv
rtl/udmn_div.sv
rtl/unsigned_div_magic_number_core.sv
tb/udmn_result_check.sv
tb/tb_top.sv
